// ----- src/scrc_pkg.sv -----
// scissor clip stack package: operation kinds, error codes, controller states
// and default sizes for the clip stack top level
// no dependencies
package scrc_pkg;

  // default sizes
  localparam int TABLE_ENTRIES_DEF = 64;
  localparam int STACK_ENTRIES_DEF = 16;
  localparam int COORD_BITS_DEF    = 16;

  // fixed width of the index fields on the ports
  localparam int IDX_BITS = 6;

  // operation kinds
  typedef enum logic [1:0] {
    KIND_PUSH  = 2'd0,
    KIND_POP   = 2'd1,
    KIND_RESET = 2'd2,
    KIND_READ  = 2'd3
  } kind_t;

  // error codes
  typedef enum logic [1:0] {
    ERR_OK       = 2'd0,
    ERR_OVERFLOW = 2'd1,
    ERR_READ_MISS = 2'd2
  } err_t;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_POP_STK,
    ST_POP_TBL,
    ST_RD_TBL
  } state_t;

endpackage

// ----- src/scissor_rect_clip_stack.sv -----
// scissor clip stack top level: state table and index stack memories, top cache
// and the controller that sequences push, pop, reset and read
// depends on scrc_pkg
//
// Usage: one input beat on in_valid/in_stall carries one operation (push, pop,
// reset all, read by index); every input beat gives exactly one output beat on
// out_valid/out_stall, in order.
// Sequencing and throughput:
//   push, reset, read miss, pop to depth 0: result in the cycle after the beat,
//     next beat taken in the following cycle (one item per cycle) unless the output stalls
//   read hit: one table memory read; no new beat is taken until its result is loaded
//   pop leaving a non-empty stack: a stack memory read followed by a dependent
//     table memory read to reload the cached top rectangle; no new beat is taken meanwhile
// The top-of-stack rectangle and index sit in registers, so a push needs only
// the edge compares against the cached top and a write to each memory, with no memory read.
// Reset (rst, synchronous) clears the table count, the stack depth, the
// controller and the output valid flag; memory contents are left as they are.
// A stalled output holds its beat; no new input beat is taken until the
// output register is free or is being taken in the same cycle.
module scissor_rect_clip_stack #(
  parameter int TABLE_ENTRIES = scrc_pkg::TABLE_ENTRIES_DEF,
  parameter int STACK_ENTRIES = scrc_pkg::STACK_ENTRIES_DEF,
  parameter int COORD_BITS    = scrc_pkg::COORD_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // input channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          kind,
  input  logic signed [COORD_BITS-1:0]        clip_left,
  input  logic signed [COORD_BITS-1:0]        clip_top,
  input  logic signed [COORD_BITS-1:0]        clip_right,
  input  logic signed [COORD_BITS-1:0]        clip_bottom,
  input  logic                                intersect_parent,
  input  logic [scrc_pkg::IDX_BITS-1:0]       read_index,
  // output channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [scrc_pkg::IDX_BITS-1:0]       top_index,
  output logic                                index_valid,
  output logic signed [COORD_BITS-1:0]        rect_left,
  output logic signed [COORD_BITS-1:0]        rect_top,
  output logic signed [COORD_BITS-1:0]        rect_right,
  output logic signed [COORD_BITS-1:0]        rect_bottom,
  output logic [1:0]                          error_code
);

  localparam int TIDX = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNTW = $clog2(TABLE_ENTRIES + 1);
  localparam int SAW  = (STACK_ENTRIES > 1) ? $clog2(STACK_ENTRIES) : 1;
  localparam int SDW  = $clog2(STACK_ENTRIES + 1);
  localparam int RW   = 4 * COORD_BITS;
  localparam int WIDE = (CNTW > scrc_pkg::IDX_BITS + 1) ? CNTW : scrc_pkg::IDX_BITS + 1;
  localparam int CB   = COORD_BITS;

  // memories and their registered read data
  logic [RW-1:0]   tbl_mem [TABLE_ENTRIES];
  logic [RW-1:0]   tbl_rd;
  logic [TIDX-1:0] stk_mem [STACK_ENTRIES];
  logic [TIDX-1:0] stk_rd;

  // control state
  scrc_pkg::state_t state, state_next;
  logic [CNTW-1:0]  table_count, table_count_next;
  logic [SDW-1:0]   stack_depth, stack_depth_next;
  logic [TIDX-1:0]  top_idx, top_idx_next;
  logic [RW-1:0]    top_rect, top_rect_next;
  logic [scrc_pkg::IDX_BITS-1:0] req_idx;

  // memory port controls
  logic            tbl_we, tbl_rd_en, stk_we, stk_rd_en;
  logic [TIDX-1:0] tbl_wr_addr, tbl_rd_addr;
  logic [RW-1:0]   tbl_wr_data;
  logic [SAW-1:0]  stk_wr_addr, stk_rd_addr;
  logic [TIDX-1:0] stk_wr_data;

  // output register load
  logic                          out_load;
  logic [scrc_pkg::IDX_BITS-1:0] out_idx_next;
  logic                          out_iv_next;
  logic [RW-1:0]                 out_rect_next;
  scrc_pkg::err_t                out_err_next;

  logic            accept;
  logic            table_full, stack_full, read_hit;
  logic [SDW-1:0]  depth_less2;
  logic [RW-1:0]   push_rect;
  logic signed [CB-1:0] q_left, q_top, q_right, q_bottom;
  logic signed [CB-1:0] p_left, p_top, p_right, p_bottom;
  logic [WIDE-1:0] top_idx_wide, cnt_idx_wide, stk_idx_wide;

  // table index from the read index field
  function automatic logic [TIDX-1:0] read_index_tidx(
    input logic [scrc_pkg::IDX_BITS-1:0] idx
  );
    logic [WIDE-1:0] w;
    w = WIDE'(idx);
    return w[TIDX-1:0];
  endfunction

  assign accept      = in_valid && !in_stall;
  assign table_full  = (table_count == CNTW'(TABLE_ENTRIES));
  assign stack_full  = (stack_depth == SDW'(STACK_ENTRIES));
  assign read_hit    = (WIDE'(read_index) < WIDE'(table_count));
  assign depth_less2 = stack_depth - SDW'(2);

  // port index views of internal table indexes
  assign top_idx_wide = WIDE'(top_idx);
  assign cnt_idx_wide = WIDE'(table_count);
  assign stk_idx_wide = WIDE'(stk_rd);

  // intersection with the cached top rectangle
  always_comb begin
    p_left   = $signed(top_rect[4*CB-1 -: CB]);
    p_top    = $signed(top_rect[3*CB-1 -: CB]);
    p_right  = $signed(top_rect[2*CB-1 -: CB]);
    p_bottom = $signed(top_rect[CB-1:0]);
    q_left   = (p_left > clip_left)     ? p_left   : clip_left;
    q_top    = (p_top > clip_top)       ? p_top    : clip_top;
    q_right  = (p_right < clip_right)   ? p_right  : clip_right;
    q_bottom = (p_bottom < clip_bottom) ? p_bottom : clip_bottom;
    if (intersect_parent && (stack_depth != '0)) begin
      if ((q_bottom < q_top) || (q_right < q_left)) begin
        push_rect = '0;
      end else begin
        push_rect = {q_left, q_top, q_right, q_bottom};
      end
    end else begin
      push_rect = {clip_left, clip_top, clip_right, clip_bottom};
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      scrc_pkg::ST_IDLE: begin
        if (accept) begin
          if ((scrc_pkg::kind_t'(kind) == scrc_pkg::KIND_POP) && (stack_depth > SDW'(1))) begin
            state_next = scrc_pkg::ST_POP_STK;
          end else if ((scrc_pkg::kind_t'(kind) == scrc_pkg::KIND_READ) && read_hit) begin
            state_next = scrc_pkg::ST_RD_TBL;
          end
        end
      end
      scrc_pkg::ST_POP_STK: state_next = scrc_pkg::ST_POP_TBL;
      scrc_pkg::ST_POP_TBL: state_next = scrc_pkg::ST_IDLE;
      scrc_pkg::ST_RD_TBL:  state_next = scrc_pkg::ST_IDLE;
      default:              state_next = scrc_pkg::ST_IDLE;
    endcase
  end

  // controller outputs
  always_comb begin
    in_stall         = 1'b1;
    tbl_we           = 1'b0;
    tbl_rd_en        = 1'b0;
    stk_we           = 1'b0;
    stk_rd_en        = 1'b0;
    tbl_wr_addr      = table_count[TIDX-1:0];
    tbl_wr_data      = push_rect;
    tbl_rd_addr      = stk_rd;
    stk_wr_addr      = stack_depth[SAW-1:0];
    stk_wr_data      = table_count[TIDX-1:0];
    stk_rd_addr      = depth_less2[SAW-1:0];
    table_count_next = table_count;
    stack_depth_next = stack_depth;
    top_idx_next     = top_idx;
    top_rect_next    = top_rect;
    out_load         = 1'b0;
    out_idx_next     = '0;
    out_iv_next      = 1'b0;
    out_rect_next    = '0;
    out_err_next     = scrc_pkg::ERR_OK;
    unique case (state)
      scrc_pkg::ST_IDLE: begin
        in_stall = out_valid && out_stall;
        if (accept) begin
          unique case (scrc_pkg::kind_t'(kind))
            scrc_pkg::KIND_PUSH: begin
              out_load = 1'b1;
              if (table_full || stack_full) begin
                // report the unchanged top
                out_err_next = scrc_pkg::ERR_OVERFLOW;
                if (stack_depth != '0) begin
                  out_idx_next  = top_idx_wide[scrc_pkg::IDX_BITS-1:0];
                  out_iv_next   = 1'b1;
                  out_rect_next = top_rect;
                end
              end else begin
                tbl_we           = 1'b1;
                stk_we           = 1'b1;
                table_count_next = table_count + CNTW'(1);
                stack_depth_next = stack_depth + SDW'(1);
                top_idx_next     = table_count[TIDX-1:0];
                top_rect_next    = push_rect;
                out_idx_next     = cnt_idx_wide[scrc_pkg::IDX_BITS-1:0];
                out_iv_next      = 1'b1;
                out_rect_next    = push_rect;
              end
            end
            scrc_pkg::KIND_POP: begin
              if (stack_depth > SDW'(1)) begin
                stk_rd_en = 1'b1;
              end else begin
                out_load = 1'b1;
              end
              if (stack_depth != '0) begin
                stack_depth_next = stack_depth - SDW'(1);
              end
            end
            scrc_pkg::KIND_RESET: begin
              out_load         = 1'b1;
              table_count_next = '0;
              stack_depth_next = '0;
            end
            scrc_pkg::KIND_READ: begin
              tbl_rd_addr = read_index_tidx(read_index);
              if (read_hit) begin
                tbl_rd_en = 1'b1;
              end else begin
                out_load     = 1'b1;
                out_idx_next = read_index;
                out_err_next = scrc_pkg::ERR_READ_MISS;
              end
            end
            default: ;
          endcase
        end
      end
      scrc_pkg::ST_POP_STK: begin
        // parent index is in, fetch its rectangle
        tbl_rd_en = 1'b1;
      end
      scrc_pkg::ST_POP_TBL: begin
        top_idx_next  = stk_rd;
        top_rect_next = tbl_rd;
        out_load      = 1'b1;
        out_idx_next  = stk_idx_wide[scrc_pkg::IDX_BITS-1:0];
        out_iv_next   = 1'b1;
        out_rect_next = tbl_rd;
      end
      scrc_pkg::ST_RD_TBL: begin
        out_load      = 1'b1;
        out_idx_next  = req_idx;
        out_iv_next   = 1'b1;
        out_rect_next = tbl_rd;
      end
      default: ;
    endcase
  end

  // table memory
  always_ff @(posedge clk) begin
    if (tbl_we) begin
      tbl_mem[tbl_wr_addr] <= tbl_wr_data;
    end
    if (tbl_rd_en) begin
      tbl_rd <= tbl_mem[tbl_rd_addr];
    end
  end

  // index stack memory
  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[stk_wr_addr] <= stk_wr_data;
    end
    if (stk_rd_en) begin
      stk_rd <= stk_mem[stk_rd_addr];
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= scrc_pkg::ST_IDLE;
      table_count <= '0;
      stack_depth <= '0;
    end else begin
      state       <= state_next;
      table_count <= table_count_next;
      stack_depth <= stack_depth_next;
    end
  end

  // top cache and request index
  always_ff @(posedge clk) begin
    top_idx  <= top_idx_next;
    top_rect <= top_rect_next;
    if (accept) begin
      req_idx <= read_index;
    end
  end

  // output beat register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      top_index   <= out_idx_next;
      index_valid <= out_iv_next;
      rect_left   <= $signed(out_rect_next[4*CB-1 -: CB]);
      rect_top    <= $signed(out_rect_next[3*CB-1 -: CB]);
      rect_right  <= $signed(out_rect_next[2*CB-1 -: CB]);
      rect_bottom <= $signed(out_rect_next[CB-1:0]);
      error_code  <= out_err_next;
    end
  end

  // a pending beat is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_load |-> !(out_valid && out_stall))
    else $error("output beat overwritten while stalled");

  // stores never exceed their capacity
  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    (stack_depth <= SDW'(STACK_ENTRIES)) && (table_count <= CNTW'(TABLE_ENTRIES)))
    else $error("stack depth or table count out of range");

  // table fetch of a pop always follows its stack fetch
  a_pop_order: assert property (@(posedge clk) disable iff (rst)
    (state == scrc_pkg::ST_POP_TBL) |-> ($past(state) == scrc_pkg::ST_POP_STK))
    else $error("pop table fetch without stack fetch");

  // no input taken while a pop or read hit is still in flight
  a_busy_stall: assert property (@(posedge clk) disable iff (rst)
    (state != scrc_pkg::ST_IDLE) |-> in_stall)
    else $error("input accepted while busy");

  // a read miss never reports a valid index
  a_miss_invalid: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (error_code == scrc_pkg::ERR_READ_MISS)) |-> !index_valid)
    else $error("read miss reported as valid");

endmodule

// ----- tb/scrc_checker.sv -----
// clip stack checker: watches both channels, predicts every result beat from
// the accepted input beats and compares them in order
// depends on scrc_pkg
`timescale 1ns / 100ps

module scrc_checker (
  input  logic                          clk,
  input  logic                          rst,
  // input channel
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic [1:0]                    kind,
  input  logic [15:0]                   clip_left,
  input  logic [15:0]                   clip_top,
  input  logic [15:0]                   clip_right,
  input  logic [15:0]                   clip_bottom,
  input  logic                          intersect_parent,
  input  logic [scrc_pkg::IDX_BITS-1:0] read_index,
  // output channel
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic [scrc_pkg::IDX_BITS-1:0] top_index,
  input  logic                          index_valid,
  input  logic [15:0]                   rect_left,
  input  logic [15:0]                   rect_top,
  input  logic [15:0]                   rect_right,
  input  logic [15:0]                   rect_bottom,
  input  logic [1:0]                    error_code,
  // status for the top
  output int                            fail_count,
  output int                            pending
);

  localparam int CW    = scrc_pkg::COORD_BITS_DEF;
  localparam int TBL_N = scrc_pkg::TABLE_ENTRIES_DEF;
  localparam int STK_N = scrc_pkg::STACK_ENTRIES_DEF;
  localparam int IW    = scrc_pkg::IDX_BITS;

  typedef struct packed {
    logic [CW-1:0] left;
    logic [CW-1:0] top;
    logic [CW-1:0] right;
    logic [CW-1:0] bottom;
  } clip_box_t;

  typedef struct packed {
    logic [IW-1:0] idx;
    logic          hit;
    clip_box_t     box;
    logic [1:0]    err;
  } clip_report_t;

  // shadow copy of the state table and the index stack
  clip_box_t     box_table [TBL_N];
  logic [IW-1:0] nest_stack [STK_N];
  int            box_count;
  int            nest_depth;
  clip_report_t  report_q [$];
  int            fails = 0;
  int            queued = 0;

  assign fail_count = fails;
  assign pending    = queued;

  // report for the state on top of the stack, or an empty stack
  function automatic clip_report_t top_report(input scrc_pkg::err_t err);
    clip_report_t rep;
    rep     = '0;
    rep.err = err;
    if (nest_depth > 0) begin
      rep.idx = nest_stack[nest_depth-1];
      rep.hit = 1'b1;
      rep.box = box_table[rep.idx];
    end
    return rep;
  endfunction

  // apply one operation to the shadow state and give its report
  function automatic clip_report_t apply_clip_op(input scrc_pkg::kind_t k,
                                                 input clip_box_t req,
                                                 input logic ip,
                                                 input logic [IW-1:0] ri);
    clip_report_t rep;
    clip_box_t    box;
    clip_box_t    parent;
    rep = '0;
    box = req;
    case (k)
      scrc_pkg::KIND_PUSH: begin
        if (box_count >= TBL_N || nest_depth >= STK_N) begin
          rep = top_report(scrc_pkg::ERR_OVERFLOW);
        end else begin
          // clip against the parent, collapsing to zero when nothing is left
          if (ip && nest_depth > 0) begin
            parent = box_table[nest_stack[nest_depth-1]];
            if ($signed(parent.left) > $signed(box.left))       box.left   = parent.left;
            if ($signed(parent.top) > $signed(box.top))         box.top    = parent.top;
            if ($signed(parent.right) < $signed(box.right))     box.right  = parent.right;
            if ($signed(parent.bottom) < $signed(box.bottom))   box.bottom = parent.bottom;
            if ($signed(box.bottom) < $signed(box.top) ||
                $signed(box.right) < $signed(box.left))         box        = '0;
          end
          box_table[box_count]   = box;
          nest_stack[nest_depth] = IW'(box_count);
          box_count++;
          nest_depth++;
          rep = top_report(scrc_pkg::ERR_OK);
        end
      end
      scrc_pkg::KIND_POP: begin
        if (nest_depth > 0) nest_depth--;
        rep = top_report(scrc_pkg::ERR_OK);
      end
      scrc_pkg::KIND_RESET: begin
        box_count  = 0;
        nest_depth = 0;
        rep        = '0;
      end
      default: begin
        rep.idx = ri;
        if (int'(ri) < box_count) begin
          rep.hit = 1'b1;
          rep.box = box_table[ri];
        end else begin
          rep.err = scrc_pkg::ERR_READ_MISS;
        end
      end
    endcase
    return rep;
  endfunction

  // compare the result beat first, then predict from the input beat
  always @(posedge clk) begin
    clip_report_t got;
    clip_report_t want;
    clip_report_t pred;
    if (rst) begin
      box_count  = 0;
      nest_depth = 0;
      report_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        got = {top_index, index_valid, rect_left, rect_top, rect_right, rect_bottom,
               error_code};
        if (report_q.size() == 0) begin
          $display("%0t ns: result beat with none expected: idx=%0d hit=%0b err=%0d",
                   $time, top_index, index_valid, error_code);
          fails++;
        end else begin
          want = report_q.pop_front();
          if (got !== want) begin
            $display({"%0t ns: mismatch expected idx=%0d hit=%0b rect=(%0d,%0d,%0d,%0d) ",
                      "err=%0d actual idx=%0d hit=%0b rect=(%0d,%0d,%0d,%0d) err=%0d"},
                     $time, want.idx, want.hit, $signed(want.box.left),
                     $signed(want.box.top), $signed(want.box.right),
                     $signed(want.box.bottom), want.err, got.idx, got.hit,
                     $signed(got.box.left), $signed(got.box.top),
                     $signed(got.box.right), $signed(got.box.bottom), got.err);
            fails++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        pred = apply_clip_op(scrc_pkg::kind_t'(kind),
                             {clip_left, clip_top, clip_right, clip_bottom},
                             intersect_parent, read_index);
        report_q = {report_q, pred};
      end
    end
    queued = report_q.size();
  end

endmodule

// ----- tb/tb_scissor_rect_clip_stack.sv -----
// clip stack testbench top: clock, reset, directed and random operation beats
// with random gaps and stalls, and the final verdict
// depends on scrc_pkg, scissor_rect_clip_stack and scrc_checker
`timescale 1ns / 100ps

module tb_scissor_rect_clip_stack;

  localparam int CW          = scrc_pkg::COORD_BITS_DEF;
  localparam int IW          = scrc_pkg::IDX_BITS;
  localparam int CYCLE_LIMIT = 600000;
  localparam int PHASE_ITEMS = 200;

  logic          clk;
  logic          rst;
  logic          in_valid;
  logic          in_stall;
  logic [1:0]    kind;
  logic [CW-1:0] clip_left;
  logic [CW-1:0] clip_top;
  logic [CW-1:0] clip_right;
  logic [CW-1:0] clip_bottom;
  logic          intersect_parent;
  logic [IW-1:0] read_index;
  logic          out_valid;
  logic          out_stall;
  logic [IW-1:0] top_index;
  logic          index_valid;
  logic [CW-1:0] rect_left;
  logic [CW-1:0] rect_top;
  logic [CW-1:0] rect_right;
  logic [CW-1:0] rect_bottom;
  logic [1:0]    error_code;

  int fail_count;
  int pending;
  int cycle_count = 0;
  int quiet = 0;        // no new gaps and no new random stall runs while set
  int hold_req = 0;     // long receiver hold-off asked by the stimulus
  int written_est = 0;  // rough count of table entries, to aim reads at hits

  scissor_rect_clip_stack u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .kind(kind),
    .clip_left(clip_left), .clip_top(clip_top), .clip_right(clip_right),
    .clip_bottom(clip_bottom), .intersect_parent(intersect_parent),
    .read_index(read_index),
    .out_valid(out_valid), .out_stall(out_stall), .top_index(top_index),
    .index_valid(index_valid), .rect_left(rect_left), .rect_top(rect_top),
    .rect_right(rect_right), .rect_bottom(rect_bottom), .error_code(error_code)
  );

  scrc_checker u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .kind(kind),
    .clip_left(clip_left), .clip_top(clip_top), .clip_right(clip_right),
    .clip_bottom(clip_bottom), .intersect_parent(intersect_parent),
    .read_index(read_index),
    .out_valid(out_valid), .out_stall(out_stall), .top_index(top_index),
    .index_valid(index_valid), .rect_left(rect_left), .rect_top(rect_top),
    .rect_right(rect_right), .rect_bottom(rect_bottom), .error_code(error_code),
    .fail_count(fail_count), .pending(pending)
  );

  // clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("scissor_rect_clip_stack verification failed");
      $finish;
    end
  end

  // length of an idle or stall run: mostly short, a few long
  function automatic int run_length();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 75) return $urandom_range(1, 3);
    if (roll < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 80);
  endfunction

  // receiver: random stall runs, plus a long hold-off on request
  int hold_left = 0;
  int stall_run = 0;
  always @(negedge clk) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (stall_run > 0) begin
      stall_run--;
    end else if (quiet != 0) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < 30);
      stall_run = run_length() - 1;
    end
  end

  // one input beat, after an optional random gap; returns once accepted
  task automatic send_op(input scrc_pkg::kind_t k, input logic [CW-1:0] l,
                         input logic [CW-1:0] t, input logic [CW-1:0] r,
                         input logic [CW-1:0] b, input logic ip,
                         input logic [IW-1:0] ri);
    int gap;
    gap = 0;
    if (quiet == 0 && $urandom_range(0, 99) >= 60) gap = run_length();
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    kind             <= k;
    clip_left        <= l;
    clip_top         <= t;
    clip_right       <= r;
    clip_bottom      <= b;
    intersect_parent <= ip;
    read_index       <= ri;
    in_valid         <= 1'b1;
    do @(posedge clk); while (in_stall);
    if (k == scrc_pkg::KIND_PUSH && written_est < scrc_pkg::TABLE_ENTRIES_DEF) written_est++;
    if (k == scrc_pkg::KIND_RESET) written_est = 0;
  endtask

  // drop valid and wait until every result has come back
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  function automatic logic [CW-1:0] extreme_coord();
    case ($urandom_range(0, 3))
      0:       return {1'b1, {(CW-1){1'b0}}};
      1:       return {1'b0, {(CW-1){1'b1}}};
      2:       return '0;
      default: return '1;
    endcase
  endfunction

  // push beat: mostly well-formed boxes, some raw and extreme edges
  task automatic push_random();
    int style;
    int x0;
    int y0;
    logic [CW-1:0] l, t, r, b;
    style = $urandom_range(0, 9);
    if (style < 7) begin
      x0 = int'($urandom_range(0, 8000)) - 4000;
      y0 = int'($urandom_range(0, 8000)) - 4000;
      l  = CW'(x0);
      t  = CW'(y0);
      r  = CW'(x0 + int'($urandom_range(0, 3000)));
      b  = CW'(y0 + int'($urandom_range(0, 3000)));
    end else if (style < 9) begin
      l = CW'($urandom);
      t = CW'($urandom);
      r = CW'($urandom);
      b = CW'($urandom);
    end else begin
      l = extreme_coord();
      t = extreme_coord();
      r = extreme_coord();
      b = extreme_coord();
    end
    send_op(scrc_pkg::KIND_PUSH, l, t, r, b, ($urandom_range(0, 99) < 80), IW'($urandom));
  endtask

  // one random beat with the given operation mix in percent
  task automatic random_op(input int push_w, input int pop_w, input int reset_w);
    int roll;
    logic [IW-1:0] ri;
    roll = $urandom_range(0, 99);
    if (roll < push_w) begin
      push_random();
    end else if (roll < push_w + pop_w) begin
      send_op(scrc_pkg::KIND_POP, CW'($urandom), CW'($urandom), CW'($urandom),
              CW'($urandom), 1'($urandom), IW'($urandom));
    end else if (roll < push_w + pop_w + reset_w) begin
      send_op(scrc_pkg::KIND_RESET, CW'($urandom), CW'($urandom), CW'($urandom),
              CW'($urandom), 1'($urandom), IW'($urandom));
    end else begin
      if (written_est > 0 && $urandom_range(0, 99) < 80)
        ri = IW'($urandom_range(0, written_est - 1));
      else
        ri = IW'($urandom);
      send_op(scrc_pkg::KIND_READ, CW'($urandom), CW'($urandom), CW'($urandom),
              CW'($urandom), 1'($urandom), ri);
    end
  endtask

  // operation mixes of the random phases: push, pop, reset percent and quiet flag
  int mix_push  [8] = '{45, 70, 45, 50, 40, 60, 35, 55};
  int mix_pop   [8] = '{25, 15, 40, 30, 40, 20, 35, 30};
  int mix_reset [8] = '{ 5,  2,  0,  3,  1,  4, 10,  1};
  int mix_quiet [8] = '{ 0,  1,  0,  0,  1,  0,  0,  1};

  localparam logic [CW-1:0] C_MIN = {1'b1, {(CW-1){1'b0}}};
  localparam logic [CW-1:0] C_MAX = {1'b0, {(CW-1){1'b1}}};

  initial begin
    rst              = 1'b1;
    in_valid         = 1'b0;
    kind             = scrc_pkg::KIND_PUSH;
    clip_left        = '0;
    clip_top         = '0;
    clip_right       = '0;
    clip_bottom      = '0;
    intersect_parent = 1'b0;
    read_index       = '0;
    out_stall        = 1'b0;
    repeat (4) @(negedge clk);
    rst <= 1'b0;

    // directed: empty stack, misses, clipping cases, pops, reset
    send_op(scrc_pkg::KIND_POP, '0, '0, '0, '0, 1'b0, '0);
    send_op(scrc_pkg::KIND_READ, '0, '0, '0, '0, 1'b0, '1);
    send_op(scrc_pkg::KIND_READ, '0, '0, '0, '0, 1'b0, '0);
    // intersect asked on an empty stack keeps the box
    send_op(scrc_pkg::KIND_PUSH, C_MIN, C_MIN, C_MAX, C_MAX, 1'b1, '0);
    send_op(scrc_pkg::KIND_PUSH, CW'(-100), CW'(50), CW'(400), CW'(900), 1'b1, '0);
    send_op(scrc_pkg::KIND_PUSH, CW'(500), CW'(1000), CW'(600), CW'(1200), 1'b1, '0);
    // inverted box stored as given without intersect
    send_op(scrc_pkg::KIND_PUSH, C_MAX, C_MAX, C_MIN, C_MIN, 1'b0, '0);
    send_op(scrc_pkg::KIND_PUSH, CW'(-16), CW'(-16), CW'(16), CW'(16), 1'b1, '0);
    for (int i = 0; i < 5; i++) send_op(scrc_pkg::KIND_READ, '0, '0, '0, '0, 1'b0, IW'(i));
    send_op(scrc_pkg::KIND_READ, '0, '0, '0, '0, 1'b0, IW'(5));
    send_op(scrc_pkg::KIND_READ, '1, '1, '1, '1, 1'b1, '1);
    for (int i = 0; i < 6; i++) send_op(scrc_pkg::KIND_POP, '0, '0, '0, '0, 1'b0, '0);
    send_op(scrc_pkg::KIND_PUSH, '1, '1, '1, '1, 1'b1, '0);
    send_op(scrc_pkg::KIND_RESET, '1, '1, '1, '1, 1'b1, '1);
    send_op(scrc_pkg::KIND_READ, '0, '0, '0, '0, 1'b0, '0);
    send_op(scrc_pkg::KIND_PUSH, C_MAX, C_MIN, C_MAX, C_MIN, 1'b1, '0);

    // random phases
    for (int p = 0; p < 8; p++) begin
      if (p == 3 || p == 6) drain();
      quiet = mix_quiet[p];
      if (p == 2) hold_req = 300;
      for (int n = 0; n < PHASE_ITEMS; n++) random_op(mix_push[p], mix_pop[p], mix_reset[p]);
    end

    drain();
    repeat (20) @(negedge clk);
    if (fail_count == 0) begin
      $display("scissor_rect_clip_stack verification clean");
    end else begin
      $display("scissor_rect_clip_stack verification failed");
    end
    $finish;
  end

endmodule
